// ===== rtl/core/icmp_rc_pkg.sv =====
`timescale 1ns / 1ps

package icmp_rc_pkg;

	localparam int LENGTH_BITS_DEF = 16;
	localparam int HDR_W           = 6;
	localparam int ICMP_HDR_BYTES  = 4;
	localparam int BYTE_W          = 8;
	localparam int SUM_W           = 16;
	localparam int PLEN_W          = 16;
	localparam logic [3:0] HDR_NIBBLE_MASK = 4'hf;

	// result transaction layout, lowest bit first
	localparam int TYPE_LSB  = 0;
	localparam int CODE_LSB  = TYPE_LSB + BYTE_W;
	localparam int RXSUM_LSB = CODE_LSB + BYTE_W;
	localparam int CSUM_LSB  = RXSUM_LSB + SUM_W;
	localparam int MATCH_BIT = CSUM_LSB + SUM_W;
	localparam int PLEN_LSB  = MATCH_BIT + 1;
	localparam int SHORT_BIT = PLEN_LSB + PLEN_W;
	localparam int OUT_BITS  = SHORT_BIT + 1;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic [BYTE_W-1:0] icmp_type;
		logic [BYTE_W-1:0] icmp_code;
		logic [SUM_W-1:0]  received_sum;
		logic [SUM_W-1:0]  computed_sum;
		logic              sum_matches;
		logic [PLEN_W-1:0] payload_length;
		logic              too_short;
	} result_t;

	// ones' complement add with end-around carry
	function automatic logic [SUM_W-1:0] oc_add(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W-1:0] + {{(SUM_W-1){1'b0}}, s[SUM_W]};
	endfunction

endpackage

// ===== rtl/core/icmp_receive_checker.sv =====
`timescale 1ns / 1ps

// channel  dir  tdata                                         tlast      tuser
// s_*      in   [7:0] packet_byte                             last_byte  -
// m_*      out  [7:0] icmp_type [15:8] icmp_code              -          -
//               [31:16] received_sum [47:32] computed_sum
//               [48] sum_matches [64:49] payload_length
//               [65] too_short [71:66] zero
//
// one byte per cycle sustained while a held result does not stall the input; each byte
// passes through the input register, and the result for a datagram is loaded into the result
// register as its last byte leaves the input register with the result register free
// the per-byte checksum add and the end fold sit between the input and result registers
// arst_n clears the valid bits and all per-datagram state
// a held result only stalls the input when a further last byte reaches the input register

module icmp_receive_checker #(
	parameter int LENGTH_BITS = icmp_rc_pkg::LENGTH_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // packet_byte
	input  logic                           s_tlast,  // last_byte
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [icmp_rc_pkg::OUT_W-1:0]  m_tdata   // icmp_type, icmp_code, received_sum,
	                                                 // computed_sum, sum_matches,
	                                                 // payload_length, too_short
);

	localparam int HW = icmp_rc_pkg::HDR_W;
	localparam int SW = icmp_rc_pkg::SUM_W;
	localparam int BW = icmp_rc_pkg::BYTE_W;
	localparam int PW = icmp_rc_pkg::PLEN_W;

	logic          valid_s1;
	logic [BW-1:0] byte_s1;
	logic          last_s1;

	logic [LENGTH_BITS-1:0] byte_position_q;
	logic [HW-1:0]          header_bytes_q;
	logic [SW-1:0]          running_sum_q;
	logic [BW-1:0]          high_byte_hold_q;
	logic                   odd_phase_q;
	logic [BW-1:0]          type_hold_q;
	logic [BW-1:0]          code_hold_q;
	logic [SW-1:0]          sum_field_hold_q;

	logic [LENGTH_BITS-1:0] pos_nxt;
	logic [HW-1:0]          hdr_nxt;
	logic [SW-1:0]          sum_nxt;
	logic [BW-1:0]          high_nxt;
	logic                   odd_nxt;
	logic [BW-1:0]          type_nxt;
	logic [BW-1:0]          code_nxt;
	logic [SW-1:0]          field_nxt;
	logic [LENGTH_BITS-1:0] off;
	logic [BW-1:0]          v;
	logic [SW-1:0]          total;
	logic [SW-1:0]          computed;
	logic [LENGTH_BITS:0]   len_ext;
	logic [LENGTH_BITS:0]   need_ext;
	logic [LENGTH_BITS-1:0] plen;

	icmp_rc_pkg::result_t res;
	logic                 out_valid_q;
	icmp_rc_pkg::result_t out_q;

	logic out_free;
	logic s1_go;

	assign out_free = !out_valid_q || m_tready;
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// per-byte update
	always_comb begin
		hdr_nxt   = header_bytes_q;
		sum_nxt   = running_sum_q;
		high_nxt  = high_byte_hold_q;
		odd_nxt   = odd_phase_q;
		type_nxt  = type_hold_q;
		code_nxt  = code_hold_q;
		field_nxt = sum_field_hold_q;
		v         = byte_s1;
		if (byte_position_q == '0) begin
			hdr_nxt = {byte_s1[3:0] & icmp_rc_pkg::HDR_NIBBLE_MASK, 2'b00};
		end
		off = byte_position_q - LENGTH_BITS'(hdr_nxt);
		if (byte_position_q >= LENGTH_BITS'(hdr_nxt)) begin
			case (off)
				LENGTH_BITS'(0): type_nxt = byte_s1;
				LENGTH_BITS'(1): code_nxt = byte_s1;
				LENGTH_BITS'(2): begin
					field_nxt[SW-1:BW] = byte_s1;
					v = '0;
				end
				LENGTH_BITS'(3): begin
					field_nxt[BW-1:0] = byte_s1;
					v = '0;
				end
				default: ;
			endcase
			if (!odd_phase_q) begin
				high_nxt = v;
				odd_nxt  = 1'b1;
			end else begin
				sum_nxt = icmp_rc_pkg::oc_add(running_sum_q, {high_byte_hold_q, v});
				odd_nxt = 1'b0;
			end
		end
		pos_nxt = (byte_position_q != '1) ? byte_position_q + 1'b1 : byte_position_q;
	end

	// result of a datagram ending on this byte
	always_comb begin
		total    = odd_nxt ? icmp_rc_pkg::oc_add(sum_nxt, {high_nxt, {BW{1'b0}}}) : sum_nxt;
		computed = ~total;
		len_ext  = {1'b0, pos_nxt};
		need_ext = (LENGTH_BITS+1)'(hdr_nxt) + (LENGTH_BITS+1)'(icmp_rc_pkg::ICMP_HDR_BYTES);
		plen     = pos_nxt - LENGTH_BITS'(hdr_nxt)
			- LENGTH_BITS'(icmp_rc_pkg::ICMP_HDR_BYTES);
		res      = '0;
		if (len_ext < need_ext) begin
			res.too_short = 1'b1;
		end else begin
			res.icmp_type      = type_nxt;
			res.icmp_code      = code_nxt;
			res.received_sum   = field_nxt;
			res.computed_sum   = computed;
			res.sum_matches    = (computed == field_nxt);
			res.payload_length = PW'(plen);
		end
	end

	// per-datagram state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			header_bytes_q   <= '0;
			running_sum_q    <= '0;
			high_byte_hold_q <= '0;
			odd_phase_q      <= 1'b0;
			type_hold_q      <= '0;
			code_hold_q      <= '0;
			sum_field_hold_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				byte_position_q  <= '0;
				header_bytes_q   <= '0;
				running_sum_q    <= '0;
				high_byte_hold_q <= '0;
				odd_phase_q      <= 1'b0;
				type_hold_q      <= '0;
				code_hold_q      <= '0;
				sum_field_hold_q <= '0;
			end else begin
				byte_position_q  <= pos_nxt;
				header_bytes_q   <= hdr_nxt;
				running_sum_q    <= sum_nxt;
				high_byte_hold_q <= high_nxt;
				odd_phase_q      <= odd_nxt;
				type_hold_q      <= type_nxt;
				code_hold_q      <= code_nxt;
				sum_field_hold_q <= field_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		(icmp_rc_pkg::OUT_W - icmp_rc_pkg::OUT_BITS)'(0),
		out_q.too_short,
		out_q.payload_length,
		out_q.sum_matches,
		out_q.computed_sum,
		out_q.received_sum,
		out_q.icmp_code,
		out_q.icmp_type
	};

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && last_s1) |=> (byte_position_q == '0 && !odd_phase_q
			&& running_sum_q == '0))
		else $error("datagram state not cleared after last byte");

	a_short_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.too_short) |-> (out_q.payload_length == '0
			&& out_q.computed_sum == '0 && !out_q.sum_matches))
		else $error("short datagram result carries non-zero fields");

	a_match_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_q.too_short) |->
			(out_q.sum_matches == (out_q.received_sum == out_q.computed_sum)))
		else $error("match flag disagrees with checksums");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(s1_go && last_s1))
		else $error("pending result overwritten");

endmodule
